### sv/pivot_affine_point_transform_assert.svh
// assertion macros used by the port-level checker file
`ifndef PIVOT_AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define PIVOT_AFFINE_POINT_TRANSFORM_ASSERT_SVH

// antecedent implies consequent on the same edge
`define APT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define APT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### sv/apt_pkg.sv
// constants, codes and trig table builder for the pivot affine point transform
package apt_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int FACTOR_WIDTH       = 16;
  localparam int FACTOR_FRAC        = 8;
  localparam int ANGLE_WIDTH        = 9;
  localparam int MODE_WIDTH         = 3;
  localparam int REG_IDX_WIDTH      = 3;
  localparam int DEG_COUNT          = 360;
  localparam int LATENCY            = 5;

  localparam logic [MODE_WIDTH-1:0] MODE_ROTATE  = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SCALE   = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_SHEAR   = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_REFL_H  = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_REFL_V  = 3'd4;

  localparam logic [REG_IDX_WIDTH-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_PIVOT_X  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_PIVOT_Y  = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ANGLE    = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FACTOR_X = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FACTOR_Y = 3'd5;

  localparam logic signed [FACTOR_WIDTH-1:0] FACTOR_ONE = 16'sd256;

  localparam real PI_APPROX = 3.1415;
  localparam real DEG_HALF_TURN = 180.0;

  typedef logic signed [31:0] trig_tab_t [DEG_COUNT];

  // sin or cos per whole degree, rounded half away from zero
  function automatic trig_tab_t build_trig(int frac_bits, bit want_cos);
    trig_tab_t tab;
    real ang;
    real v;
    real scl;
    scl = real'(longint'(1) <<< frac_bits);
    for (int d = 0; d < DEG_COUNT; d++) begin
      ang = real'(d) * PI_APPROX / DEG_HALF_TURN;
      v = want_cos ? $cos(ang) : $sin(ang);
      v = v * scl;
      if (v >= 0.0) begin
        tab[d] = $rtoi($floor(v + 0.5));
      end else begin
        tab[d] = -$rtoi($floor(-v + 0.5));
      end
    end
    return tab;
  endfunction

endpackage

### sv/pivot_affine_point_transform.sv
// pivot affine point transform: rotate, scale, shear or reflect a point about a pivot
//
// One point word enters on any cycle with start high; busy stays low, so a
// new word can follow every cycle. The result appears on out_x, out_y and
// saturated with done high for one cycle; trig table read, multiply, sum,
// truncating shift with base add, and clamp each have a register stage in
// that order. The receiver cannot stall the block.
// Registers on the cfg port take effect for words taken after the write.
module pivot_affine_point_transform
  import apt_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     point_x,
  input  logic signed [COORD_WIDTH-1:0]     point_y,
  output logic                              done,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic                              saturated,
  input  logic                              cfg_we,
  input  logic [REG_IDX_WIDTH-1:0]          cfg_addr,
  input  logic [((COORD_WIDTH > FACTOR_WIDTH) ? COORD_WIDTH : FACTOR_WIDTH)-1:0] cfg_wdata
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int AW = (TW > FACTOR_WIDTH) ? TW : FACTOR_WIDTH;
  localparam int PW = AW + DW;
  localparam int SW = PW + 1;
  localparam int RW = SW + 1;
  localparam int XW = COORD_WIDTH + 2;

  localparam trig_tab_t SIN_TAB = build_trig(TRIG_FRAC_BITS, 1'b0);
  localparam trig_tab_t COS_TAB = build_trig(TRIG_FRAC_BITS, 1'b1);

  localparam logic signed [SW-1:0] ROT_BIAS = SW'((longint'(1) <<< TRIG_FRAC_BITS) - 1);
  localparam logic signed [SW-1:0] FAC_BIAS = SW'((longint'(1) <<< FACTOR_FRAC) - 1);
  localparam logic signed [RW-1:0] OUT_MAX  = RW'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] OUT_MIN  = -OUT_MAX - RW'(1);

  // configuration registers
  logic [MODE_WIDTH-1:0]          mode;
  logic signed [COORD_WIDTH-1:0]  pivot_x;
  logic signed [COORD_WIDTH-1:0]  pivot_y;
  logic [ANGLE_WIDTH-1:0]         angle_deg;
  logic signed [FACTOR_WIDTH-1:0] factor_x;
  logic signed [FACTOR_WIDTH-1:0] factor_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ROTATE;
      pivot_x   <= '0;
      pivot_y   <= '0;
      angle_deg <= '0;
      factor_x  <= FACTOR_ONE;
      factor_y  <= FACTOR_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:     mode      <= cfg_wdata[MODE_WIDTH-1:0];
        REG_PIVOT_X:  pivot_x   <= cfg_wdata[COORD_WIDTH-1:0];
        REG_PIVOT_Y:  pivot_y   <= cfg_wdata[COORD_WIDTH-1:0];
        REG_ANGLE:    angle_deg <= cfg_wdata[ANGLE_WIDTH-1:0];
        REG_FACTOR_X: factor_x  <= cfg_wdata[FACTOR_WIDTH-1:0];
        REG_FACTOR_Y: factor_y  <= cfg_wdata[FACTOR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: offsets and trig table read
  logic [ANGLE_WIDTH-1:0] angle_idx;
  assign angle_idx = (angle_deg >= ANGLE_WIDTH'(DEG_COUNT))
                     ? angle_deg - ANGLE_WIDTH'(DEG_COUNT) : angle_deg;

  logic                           v1;
  logic [MODE_WIDTH-1:0]          mode1;
  logic signed [COORD_WIDTH-1:0]  px1, py1, pvx1, pvy1;
  logic signed [DW-1:0]           dx1, dy1;
  logic signed [FACTOR_WIDTH-1:0] fx1, fy1;
  logic signed [TW-1:0]           cos1, sin1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= mode;
    px1   <= point_x;
    py1   <= point_y;
    pvx1  <= pivot_x;
    pvy1  <= pivot_y;
    dx1   <= DW'(point_x) - DW'(pivot_x);
    dy1   <= DW'(point_y) - DW'(pivot_y);
    fx1   <= factor_x;
    fy1   <= factor_y;
    cos1  <= COS_TAB[angle_idx][TW-1:0];
    sin1  <= SIN_TAB[angle_idx][TW-1:0];
  end

  // stage 2: four shared multipliers
  logic signed [AW-1:0] ma0, ma1, ma2, ma3;
  logic signed [DW-1:0] mb0, mb1, mb2, mb3;

  always_comb begin
    ma0 = '0; ma1 = '0; ma2 = '0; ma3 = '0;
    mb0 = '0; mb1 = '0; mb2 = '0; mb3 = '0;
    case (mode1)
      MODE_ROTATE: begin
        ma0 = AW'(cos1); mb0 = dx1;
        ma1 = AW'(sin1); mb1 = dy1;
        ma2 = AW'(sin1); mb2 = dx1;
        ma3 = AW'(cos1); mb3 = dy1;
      end
      MODE_SCALE: begin
        ma0 = AW'(fx1); mb0 = dx1;
        ma2 = AW'(fy1); mb2 = dy1;
      end
      MODE_SHEAR: begin
        ma0 = AW'(fx1); mb0 = dy1;
        ma2 = AW'(fy1); mb2 = dx1;
      end
      default: ;
    endcase
  end

  logic                          v2;
  logic [MODE_WIDTH-1:0]         mode2;
  logic signed [COORD_WIDTH-1:0] px2, py2, pvx2, pvy2;
  logic signed [PW-1:0]          p0, p1, p2, p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mode2 <= mode1;
    px2   <= px1;
    py2   <= py1;
    pvx2  <= pvx1;
    pvy2  <= pvy1;
    p0    <= PW'(ma0) * PW'(mb0);
    p1    <= PW'(ma1) * PW'(mb1);
    p2    <= PW'(ma2) * PW'(mb2);
    p3    <= PW'(ma3) * PW'(mb3);
  end

  // stage 3: sums, base and direct results
  logic                          v3, arith3, rot3;
  logic signed [SW-1:0]          sx3, sy3;
  logic signed [COORD_WIDTH-1:0] bx3, by3;
  logic signed [XW-1:0]          dirx3, diry3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sx3    <= SW'(p0) - SW'(p1);
    sy3    <= SW'(p2) + SW'(p3);
    rot3   <= (mode2 == MODE_ROTATE);
    arith3 <= (mode2 == MODE_ROTATE) || (mode2 == MODE_SCALE) || (mode2 == MODE_SHEAR);
    bx3    <= (mode2 == MODE_SHEAR) ? px2 : pvx2;
    by3    <= (mode2 == MODE_SHEAR) ? py2 : pvy2;
    dirx3  <= (mode2 == MODE_REFL_V) ? (XW'(pvx2) <<< 1) - XW'(px2) : XW'(px2);
    diry3  <= (mode2 == MODE_REFL_H) ? (XW'(pvy2) <<< 1) - XW'(py2) : XW'(py2);
  end

  // stage 4: truncate toward zero and add base
  logic signed [SW-1:0] biasx, biasy, qx, qy;

  always_comb begin
    biasx = sx3 + (sx3[SW-1] ? (rot3 ? ROT_BIAS : FAC_BIAS) : SW'(0));
    biasy = sy3 + (sy3[SW-1] ? (rot3 ? ROT_BIAS : FAC_BIAS) : SW'(0));
    qx    = rot3 ? (biasx >>> TRIG_FRAC_BITS) : (biasx >>> FACTOR_FRAC);
    qy    = rot3 ? (biasy >>> TRIG_FRAC_BITS) : (biasy >>> FACTOR_FRAC);
  end

  logic                 v4;
  logic signed [RW-1:0] rx4, ry4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    rx4 <= arith3 ? (RW'(qx) + RW'(bx3)) : RW'(dirx3);
    ry4 <= arith3 ? (RW'(qy) + RW'(by3)) : RW'(diry3);
  end

  // stage 5: clamp to coordinate range
  logic signed [RW-1:0] cx, cy;
  logic                 satx, saty;

  always_comb begin
    cx = rx4;
    cy = ry4;
    satx = 1'b0;
    saty = 1'b0;
    if (rx4 > OUT_MAX) begin
      cx = OUT_MAX; satx = 1'b1;
    end else if (rx4 < OUT_MIN) begin
      cx = OUT_MIN; satx = 1'b1;
    end
    if (ry4 > OUT_MAX) begin
      cy = OUT_MAX; saty = 1'b1;
    end else if (ry4 < OUT_MIN) begin
      cy = OUT_MIN; saty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    out_x     <= cx[COORD_WIDTH-1:0];
    out_y     <= cy[COORD_WIDTH-1:0];
    saturated <= satx | saty;
  end

endmodule

### sv/apt_checker.sv
// port-level checker for the pivot affine point transform, with its bind
`include "pivot_affine_point_transform_assert.svh"

module apt_checker
  import apt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic                          saturated
);

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  `APT_ASSERT_NEVER(a_never_busy, clk, rst, busy, "busy raised")

  `APT_ASSERT_IMPLY(a_latency, clk, rst,
    !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) &&
    !$past(rst, LATENCY), done == $past(start && !busy, LATENCY),
    "done does not follow an accepted word by the pipeline latency")

  `APT_ASSERT_IMPLY(a_sat_clamped, clk, rst, done && saturated,
    out_x == CMAX || out_x == CMIN || out_y == CMAX || out_y == CMIN,
    "saturated word without a clamped coordinate")

  `APT_ASSERT_IMPLY(a_quiet_after_reset, clk, rst, $past(rst), !done,
    "done right after reset")

endmodule

bind pivot_affine_point_transform apt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_apt_checker (.*);
